### src/tcpu_pkg.sv
`timescale 1ns / 1ps

package tcpu_pkg;

    localparam int NUM_REGS  = 8;
    localparam int REG_W     = 16;
    localparam int RIDX_W    = 3;
    localparam int PC_W      = 12;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    localparam logic [REG_W-1:0] REG_RESET = 16'h0001;

    // instruction format, bits 1:0
    typedef enum logic [1:0] {
        FMT_REG = 2'd0,
        FMT_IMM = 2'd1,
        FMT_BR  = 2'd2,
        FMT_NOP = 2'd3
    } t_fmt;

    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_SUB = 3'd1,
        ALU_AND = 3'd2,
        ALU_OR  = 3'd3,
        ALU_XOR = 3'd4,
        ALU_SHL = 3'd5,
        ALU_SHR = 3'd6,
        ALU_CMP = 3'd7
    } t_alu_op;

    // compare results and branch conditions share this coding
    localparam logic [1:0] CMP_EQ    = 2'd0;
    localparam logic [1:0] CMP_GT    = 2'd1;
    localparam logic [1:0] CMP_LT    = 2'd2;
    localparam logic [1:0] CMP_NEVER = 2'd3;

    typedef struct packed {
        t_fmt              fmt;
        t_alu_op           op;
        logic [RIDX_W-1:0] rx;
        logic [RIDX_W-1:0] ry;
        logic [7:0]        imm;
        logic              taken;
        logic [PC_W-1:0]   target;
    } t_uop;

endpackage

### src/tcpu_front.sv
`timescale 1ns / 1ps

module tcpu_front (
    input  logic             i_in_valid,
    input  logic [15:0]      i_instr_word,
    input  logic [1:0]       i_compare_flag,
    input  logic             i_q_full,
    output logic             o_in_ready,
    output logic             o_push,
    output tcpu_pkg::t_uop   o_uop
);

    logic [1:0] w_cond;

    assign w_cond     = i_instr_word[3:2];
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // resolve the branch here: the flag travels with the word
    always_comb begin
        o_uop.fmt    = tcpu_pkg::t_fmt'(i_instr_word[1:0]);
        o_uop.op     = tcpu_pkg::t_alu_op'(i_instr_word[4:2]);
        o_uop.rx     = i_instr_word[15:13];
        o_uop.ry     = i_instr_word[12:10];
        o_uop.imm    = i_instr_word[12:5];
        o_uop.target = i_instr_word[15:4];
        o_uop.taken  = (i_instr_word[1:0] == tcpu_pkg::FMT_BR)
                    && (w_cond != tcpu_pkg::CMP_NEVER)
                    && (i_compare_flag == w_cond);
    end

endmodule

### src/tcpu_queue.sv
`timescale 1ns / 1ps

module tcpu_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tcpu_pkg::t_uop   i_uop,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_nempty,
    output tcpu_pkg::t_uop   o_uop
);

    tcpu_pkg::t_uop                   r_data [tcpu_pkg::QDEPTH];
    logic [tcpu_pkg::QPTR_W-1:0]      r_wptr, n_wptr;
    logic [tcpu_pkg::QPTR_W-1:0]      r_rptr, n_rptr;
    logic [tcpu_pkg::QCNT_W-1:0]      r_cnt, n_cnt;

    assign o_full   = (r_cnt == tcpu_pkg::QCNT_W'(tcpu_pkg::QDEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_uop    = r_data[r_rptr];

    always_comb begin
        n_wptr = r_wptr + tcpu_pkg::QPTR_W'(i_push);
        n_rptr = r_rptr + tcpu_pkg::QPTR_W'(i_pop);
        n_cnt  = r_cnt + tcpu_pkg::QCNT_W'(i_push) - tcpu_pkg::QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_uop;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_nempty |-> !i_pop)
        else $error("queue pop while empty");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule

### src/tcpu_back.sv
`timescale 1ns / 1ps

module tcpu_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_nempty,
    input  tcpu_pkg::t_uop                 i_uop,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [tcpu_pkg::REG_W-1:0]     o_dest_value,
    output logic [tcpu_pkg::PC_W-1:0]      o_next_pc
);

    // register file: one write port, two registered read ports
    logic [tcpu_pkg::REG_W-1:0]   r_mem [tcpu_pkg::NUM_REGS];
    logic [tcpu_pkg::NUM_REGS-1:0] r_valid;

    logic                         r_a_vld;
    tcpu_pkg::t_uop               r_a_uop;
    logic [tcpu_pkg::REG_W-1:0]   r_rd_x, r_rd_y, r_byp;
    logic                         r_x_byp, r_y_byp, r_x_ok, r_y_ok;

    logic [tcpu_pkg::PC_W-1:0]    r_pc, n_pc;
    logic                         r_out_vld;
    logic [tcpu_pkg::REG_W-1:0]   r_out_dest;

    logic                         w_out_free, w_a_fire, w_wr_en;
    logic [tcpu_pkg::REG_W-1:0]   w_x, w_y, w_b, w_alu, w_dest;

    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_a_fire   = r_a_vld && w_out_free;
    assign o_pop      = i_q_nempty && (!r_a_vld || w_a_fire);

    // an entry never written still reads as its reset value
    assign w_x = r_x_byp ? r_byp : (r_x_ok ? r_rd_x : tcpu_pkg::REG_RESET);
    assign w_y = r_y_byp ? r_byp : (r_y_ok ? r_rd_y : tcpu_pkg::REG_RESET);
    assign w_b = (r_a_uop.fmt == tcpu_pkg::FMT_IMM) ? {8'd0, r_a_uop.imm} : w_y;

    always_comb begin
        unique case (r_a_uop.op)
            tcpu_pkg::ALU_ADD: w_alu = w_x + w_b;
            tcpu_pkg::ALU_SUB: w_alu = w_x - w_b;
            tcpu_pkg::ALU_AND: w_alu = w_x & w_b;
            tcpu_pkg::ALU_OR:  w_alu = w_x | w_b;
            tcpu_pkg::ALU_XOR: w_alu = w_x ^ w_b;
            tcpu_pkg::ALU_SHL: w_alu = (w_b[15:4] == '0) ? (w_x << w_b[3:0]) : '0;
            tcpu_pkg::ALU_SHR: w_alu = (w_b[15:4] == '0) ? (w_x >> w_b[3:0]) : '0;
            tcpu_pkg::ALU_CMP: begin
                if (w_x == w_b) begin
                    w_alu = {14'd0, tcpu_pkg::CMP_EQ};
                end else if (w_x > w_b) begin
                    w_alu = {14'd0, tcpu_pkg::CMP_GT};
                end else begin
                    w_alu = {14'd0, tcpu_pkg::CMP_LT};
                end
            end
            default: w_alu = '0;
        endcase
    end

    assign w_wr_en = w_a_fire && ((r_a_uop.fmt == tcpu_pkg::FMT_REG)
                               || (r_a_uop.fmt == tcpu_pkg::FMT_IMM));
    assign w_dest  = ((r_a_uop.fmt == tcpu_pkg::FMT_REG)
                   || (r_a_uop.fmt == tcpu_pkg::FMT_IMM)) ? w_alu : w_x;
    assign n_pc    = (r_a_uop.fmt == tcpu_pkg::FMT_BR && r_a_uop.taken)
                   ? r_a_uop.target : r_pc + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_a_uop.rx] <= w_alu;
        end
        if (o_pop) begin
            r_rd_x <= r_mem[i_uop.rx];
            r_rd_y <= r_mem[i_uop.ry];
            // forward the word written in this same cycle
            r_byp   <= w_alu;
            r_x_byp <= w_wr_en && (r_a_uop.rx == i_uop.rx);
            r_y_byp <= w_wr_en && (r_a_uop.rx == i_uop.ry);
            r_x_ok  <= r_valid[i_uop.rx];
            r_y_ok  <= r_valid[i_uop.ry];
            r_a_uop <= i_uop;
        end
        if (w_a_fire) begin
            r_out_dest <= w_dest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_a_vld   <= 1'b0;
            r_pc      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_valid[r_a_uop.rx] <= 1'b1;
            end
            if (o_pop) begin
                r_a_vld <= 1'b1;
            end else if (w_a_fire) begin
                r_a_vld <= 1'b0;
            end
            if (w_a_fire) begin
                r_pc      <= n_pc;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_dest_value = r_out_dest;
    assign o_next_pc    = r_pc;

`ifndef SYNTH
    a_pc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_a_fire && !(r_a_uop.fmt == tcpu_pkg::FMT_BR && r_a_uop.taken)
        |=> r_pc == $past(r_pc + 1'b1))
        else $error("counter did not advance by one");
    a_valid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> r_valid[$past(r_a_uop.rx)])
        else $error("written register not marked valid");
    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld && !w_out_free |=> r_a_vld && $stable(r_a_uop))
        else $error("execute stage lost a stalled instruction");
    a_pc_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_a_fire |=> $stable(r_pc))
        else $error("counter moved without an instruction");
`endif

endmodule

### src/tiny_cpu_execute_unit.sv
`timescale 1ns / 1ps

// Channel  Handshake                  Payload
// input    i_in_valid / o_in_ready    i_instr_word[15:0], i_compare_flag[1:0]
// output   o_out_valid / i_out_ready  o_dest_value[15:0], o_next_pc[11:0]
//
// One instruction per cycle sustained while the output is not stalled; each result
// passes the queue write, register file read and execute into the output
// register. The counter update and register write-back happen in the same cycle.
// Reset is synchronous, active low: registers read as one, counter is zero.
// Input stays ready through an output stall until the four-entry queue fills;
// six words fit in flight (queue, execute stage, output register).

module tiny_cpu_execute_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [15:0]  i_instr_word,
    input  logic [1:0]   i_compare_flag,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [15:0]  o_dest_value,
    output logic [11:0]  o_next_pc
);

    tcpu_pkg::t_uop w_f_uop, w_q_uop;
    logic           w_push, w_pop, w_full, w_nempty;

    tcpu_front u_front (
        .i_in_valid     (i_in_valid),
        .i_instr_word   (i_instr_word),
        .i_compare_flag (i_compare_flag),
        .i_q_full       (w_full),
        .o_in_ready     (o_in_ready),
        .o_push         (w_push),
        .o_uop          (w_f_uop)
    );

    tcpu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_uop    (w_f_uop),
        .i_pop    (w_pop),
        .o_full   (w_full),
        .o_nempty (w_nempty),
        .o_uop    (w_q_uop)
    );

    tcpu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nempty   (w_nempty),
        .i_uop        (w_q_uop),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_dest_value (o_dest_value),
        .o_next_pc    (o_next_pc)
    );

endmodule
